### rtl/core/lost_track_steer_fallback_top_assert.svh
// Assertion macros for the lost-track steering fallback block.
// Used by lost_track_steer_fallback_top; expects clk and rst_n in scope.
`ifndef LOST_TRACK_STEER_FALLBACK_TOP_ASSERT_SVH
`define LOST_TRACK_STEER_FALLBACK_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LTSF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lost_track_steer_fallback_top: assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define LTSF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lost_track_steer_fallback_top: assertion failed");

`endif

### rtl/core/ltsf_pkg.sv
// Package for the lost-track steering fallback block: widths, codes, defaults
// and the request and response types of the shared arithmetic unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ltsf_pkg;

    // Field widths.
    localparam int MID_W   = 13;
    localparam int TURN_W  = 20;
    localparam int STEER_W = 9;
    localparam int MEAN_W  = 12;
    localparam int FW_W    = 13;
    localparam int DB_W    = 11;
    localparam int YD_W    = 16;
    localparam int MAG_W   = 8;

    // Yaw history ring.
    localparam int HIST_DEPTH = 8;
    localparam int PTR_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int FILL_W     = $clog2(HIST_DEPTH + 1);
    localparam logic [PTR_W-1:0]  PTR_LAST     = PTR_W'(HIST_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL    = FILL_W'(HIST_DEPTH);
    localparam logic [FILL_W-1:0] MIN_YAW_FILL = FILL_W'(2);
    localparam logic [FILL_W:0]   IDX_DEPTH    = (FILL_W + 1)'(HIST_DEPTH);

    // Shared arithmetic unit and divider.
    localparam int ALU_W     = 22;
    localparam int DIVD_W    = 14;
    localparam int REM_W     = 3;
    localparam int WSUM_W    = 3;
    localparam int DIV_CNT_W = $clog2(DIVD_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIVD_W - 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_DEADBAND   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRONG_CONFIDENCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_YAW_DEADBAND      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_MAGNITUDE    = 3'd4;

    localparam logic [FW_W-1:0]  RST_FRAME_WIDTH       = 13'd160;
    localparam logic [DB_W-1:0]  RST_CENTER_DEADBAND   = 11'd20;
    localparam logic [DB_W-1:0]  RST_STRONG_CONFIDENCE = 11'd35;
    localparam logic [YD_W-1:0]  RST_YAW_DEADBAND      = 16'd880;
    localparam logic [MAG_W-1:0] RST_TURN_MAGNITUDE    = 8'd160;

    typedef enum logic [1:0] {
        SIDE_UNKNOWN = 2'd0,
        SIDE_LEFT    = 2'd1,
        SIDE_RIGHT   = 2'd2
    } side_t;

    // Operands are two's complement; sub selects a - b, otherwise a + b.
    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             neg;
    } alu_rsp_t;

endpackage

`default_nettype wire

### rtl/core/ltsf_if.sv
// Handshake channels of the lost-track steering fallback block: input items,
// result items and configuration writes. Depends on ltsf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface ltsf_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [ltsf_pkg::MID_W-1:0]   mid_center;
    logic signed [ltsf_pkg::MID_W-1:0]   mid_below;
    logic signed [ltsf_pkg::MID_W-1:0]   mid_above;
    logic signed [ltsf_pkg::TURN_W-1:0]  lap_turn;

    modport source (output valid, mid_center, mid_below, mid_above, lap_turn, input ready);
    modport sink   (input valid, mid_center, mid_below, mid_above, lap_turn, output ready);
endinterface

interface ltsf_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ltsf_pkg::STEER_W-1:0]  steer_error;
    logic                                 used_yaw;
    logic        [1:0]                    remembered_side;
    logic                                 sample_taken;
    logic        [ltsf_pkg::MEAN_W-1:0]   sample_mid;
    logic        [ltsf_pkg::MEAN_W-1:0]   confidence;

    modport source (output valid, steer_error, used_yaw, remembered_side, sample_taken,
                    sample_mid, confidence, input ready);
    modport sink   (input valid, steer_error, used_yaw, remembered_side, sample_taken,
                    sample_mid, confidence, output ready);
endinterface

interface ltsf_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ltsf_pkg::CFG_IDX_W-1:0]      index;
    logic [ltsf_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/ltsf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ltsf_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/core/ltsf_alu.sv
// Shared add/subtract unit of the lost-track steering fallback sequencer.
// Depends on ltsf_pkg for the request and response types.
`timescale 1ns / 1ps
`default_nettype none

module ltsf_alu (
    input  wire ltsf_pkg::alu_req_t req,
    output ltsf_pkg::alu_rsp_t      rsp
);

    logic [ltsf_pkg::ALU_W-1:0] b_op;
    logic [ltsf_pkg::ALU_W-1:0] sum;

    // Subtraction is the addition of the inverted operand plus a carry in.
    assign b_op = req.sub ? ~req.b : req.b;
    assign sum  = req.a + b_op + {{(ltsf_pkg::ALU_W - 1){1'b0}}, req.sub};

    assign rsp.res = sum;
    assign rsp.neg = sum[ltsf_pkg::ALU_W-1];

endmodule

`default_nettype wire

### rtl/core/lost_track_steer_fallback_top.sv
// Top level of the lost-track steering fallback block: sequencer, registers,
// yaw ring and side tracker. Depends on ltsf_pkg, ltsf_if, ltsf_alu, ltsf_ram.
`timescale 1ns / 1ps
`default_nettype none
`include "lost_track_steer_fallback_top_assert.svh"

//  Channel   Direction  Beat contents
//  -------   ---------  -------------------------------------------------------------
//  cfg       in         register index (3 bits) and write data (16 bits), always ready
//  sample    in         mid_center, mid_below, mid_above, lap_turn
//  result    out        steer_error, used_yaw, remembered_side, sample_taken,
//                       sample_mid, confidence
//
//  The long path from an accepted sample beat to its registered result beat is the
//  14-step restoring divide of the weighted sum on the shared adder.
//  The sample channel is ready only while the sequencer sits idle, one item at a time.
//  A result waiting for the sink stalls the sequencer in its final step, not earlier.
//  rst_n clears the sequencer, the ring pointers and the side tracker, and loads the
//  register defaults; the ring contents need no clearing, the fill count guards them.

module lost_track_steer_fallback_top (
    input  wire logic      clk,
    input  wire logic      rst_n,
    ltsf_cfg_if.sink       cfg,
    ltsf_in_if.sink        sample,
    ltsf_out_if.source     result
);

    // One-hot sequencer states.
    typedef enum logic [13:0] {
        ST_IDLE      = 14'b00000000000001,
        ST_LOAD      = 14'b00000000000010,
        ST_DIV       = 14'b00000000000100,
        ST_CONF_POS  = 14'b00000000001000,
        ST_CONF_NEG  = 14'b00000000010000,
        ST_DEADBAND  = 14'b00000000100000,
        ST_TRACK     = 14'b00000001000000,
        ST_YAW_NEW   = 14'b00000010000000,
        ST_YAW_OLD   = 14'b00000100000000,
        ST_DELTA     = 14'b00001000000000,
        ST_YAW_LEFT  = 14'b00010000000000,
        ST_YAW_RIGHT = 14'b00100000000000,
        ST_DONE      = 14'b01000000000000,
        ST_SPARE     = 14'b10000000000000
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [ltsf_pkg::FW_W-1:0]  frame_width_reg;
    logic [ltsf_pkg::DB_W-1:0]  center_deadband_reg;
    logic [ltsf_pkg::DB_W-1:0]  strong_conf_reg;
    logic [ltsf_pkg::YD_W-1:0]  yaw_deadband_reg;
    logic [ltsf_pkg::MAG_W-1:0] turn_mag_reg;

    // Captured input beat.
    logic [ltsf_pkg::MID_W-1:0]  mid_c_reg;
    logic [ltsf_pkg::MID_W-1:0]  mid_b_reg;
    logic [ltsf_pkg::MID_W-1:0]  mid_a_reg;
    logic [ltsf_pkg::TURN_W-1:0] turn_reg;

    // Divider: the dividend shifts out at the top while quotient bits enter at the bottom.
    logic [ltsf_pkg::DIVD_W-1:0]    divq_reg;
    logic [ltsf_pkg::REM_W-1:0]     rem_reg;
    logic [ltsf_pkg::WSUM_W-1:0]    wsum_reg;
    logic [ltsf_pkg::DIV_CNT_W-1:0] div_cnt_reg;

    logic [ltsf_pkg::MEAN_W-1:0] conf_reg;
    ltsf_pkg::side_t             side_reg;
    logic                        taken_reg;

    // Ring and tracker state.
    logic [ltsf_pkg::PTR_W-1:0]  wp_reg;
    logic [ltsf_pkg::FILL_W-1:0] fill_reg;
    ltsf_pkg::side_t             stable_reg;
    ltsf_pkg::side_t             pend_side_reg;
    logic [1:0]                  pend_cnt_reg;

    // Yaw decision.
    logic [ltsf_pkg::TURN_W-1:0] newest_reg;
    logic [ltsf_pkg::ALU_W-1:0]  delta_reg;
    logic                        used_yaw_reg;
    logic                        yaw_left_reg;

    // Output register.
    logic                                out_valid_reg;
    logic [ltsf_pkg::STEER_W-1:0]        res_steer_reg;
    logic                                res_used_yaw_reg;
    logic [1:0]                          res_side_reg;
    logic                                res_taken_reg;
    logic [ltsf_pkg::MEAN_W-1:0]         res_mid_reg;
    logic [ltsf_pkg::MEAN_W-1:0]         res_conf_reg;

    ltsf_pkg::alu_req_t alu_req;
    ltsf_pkg::alu_rsp_t alu_rsp;

    ltsf_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Yaw ring: written while tracking, read newest then oldest.
    logic                        ram_we;
    logic [ltsf_pkg::PTR_W-1:0]  ram_raddr;
    logic [ltsf_pkg::TURN_W-1:0] ram_rdata;

    ltsf_ram #(
        .WIDTH (ltsf_pkg::TURN_W),
        .DEPTH (ltsf_pkg::HIST_DEPTH)
    ) u_yaw_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (turn_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Ring pointers. The oldest entry sits fill_count places behind the write position.
    logic [ltsf_pkg::PTR_W-1:0]  newest_ptr;
    logic [ltsf_pkg::PTR_W-1:0]  oldest_ptr;
    logic [ltsf_pkg::FILL_W:0]   wp_ext;
    logic [ltsf_pkg::FILL_W:0]   fill_ext;
    logic [ltsf_pkg::FILL_W:0]   oldest_ext;

    assign wp_ext     = (ltsf_pkg::FILL_W + 1)'(wp_reg);
    assign fill_ext   = {1'b0, fill_reg};
    assign oldest_ext = (wp_ext >= fill_ext) ? (wp_ext - fill_ext)
                                             : (wp_ext + ltsf_pkg::IDX_DEPTH - fill_ext);
    assign oldest_ptr = oldest_ext[ltsf_pkg::PTR_W-1:0];
    assign newest_ptr = (wp_reg == '0) ? ltsf_pkg::PTR_LAST : (wp_reg - 1'b1);

    assign ram_we    = (state_reg == ST_TRACK);
    assign ram_raddr = (state_reg == ST_YAW_NEW) ? newest_ptr : oldest_ptr;

    // Weighted sum of the valid mids: a negative value marks an invalid mid.
    logic                          vc;
    logic                          vb;
    logic                          va;
    logic [ltsf_pkg::DIVD_W-1:0]   wsum_sum;
    logic [ltsf_pkg::WSUM_W-1:0]   wsum_next;
    logic [ltsf_pkg::DIVD_W-1:0]   dividend_next;

    assign vc = !mid_c_reg[ltsf_pkg::MID_W-1];
    assign vb = !mid_b_reg[ltsf_pkg::MID_W-1];
    assign va = !mid_a_reg[ltsf_pkg::MID_W-1];

    assign wsum_sum = (vc ? {1'b0, mid_c_reg[ltsf_pkg::MID_W-2:0], 1'b0} : '0)
                    + (vb ? {2'b00, mid_b_reg[ltsf_pkg::MID_W-2:0]} : '0)
                    + (va ? {2'b00, mid_a_reg[ltsf_pkg::MID_W-2:0]} : '0);
    assign wsum_next = (vc ? 3'd2 : 3'd0) + {2'b00, vb} + {2'b00, va};
    // Rounding half up: add half the weight sum before dividing.
    assign dividend_next = wsum_sum + ltsf_pkg::DIVD_W'(wsum_next >> 1);

    logic [ltsf_pkg::MEAN_W-1:0] center;
    logic [ltsf_pkg::MEAN_W-1:0] mean;
    logic [ltsf_pkg::REM_W:0]    div_shift;

    assign center    = frame_width_reg[ltsf_pkg::FW_W-1:1];
    assign mean      = divq_reg[ltsf_pkg::MEAN_W-1:0];
    assign div_shift = {rem_reg, divq_reg[ltsf_pkg::DIVD_W-1]};

    // Operand selection for the shared adder, one operation per sequencer step.
    always_comb
    begin
        alu_req.a   = '0;
        alu_req.b   = '0;
        alu_req.sub = 1'b1;
        case (state_reg)
            ST_DIV:
            begin
                alu_req.a = ltsf_pkg::ALU_W'(div_shift);
                alu_req.b = ltsf_pkg::ALU_W'(wsum_reg);
            end
            ST_CONF_POS:
            begin
                alu_req.a = ltsf_pkg::ALU_W'(mean);
                alu_req.b = ltsf_pkg::ALU_W'(center);
            end
            ST_CONF_NEG:
            begin
                alu_req.a = ltsf_pkg::ALU_W'(center);
                alu_req.b = ltsf_pkg::ALU_W'(mean);
            end
            ST_DEADBAND:
            begin
                alu_req.a = ltsf_pkg::ALU_W'(center_deadband_reg);
                alu_req.b = ltsf_pkg::ALU_W'(conf_reg);
            end
            ST_TRACK:
            begin
                alu_req.a = ltsf_pkg::ALU_W'(conf_reg);
                alu_req.b = ltsf_pkg::ALU_W'(strong_conf_reg);
            end
            ST_DELTA:
            begin
                alu_req.a = {{(ltsf_pkg::ALU_W - ltsf_pkg::TURN_W)
                              {newest_reg[ltsf_pkg::TURN_W-1]}}, newest_reg};
                alu_req.b = {{(ltsf_pkg::ALU_W - ltsf_pkg::TURN_W)
                              {ram_rdata[ltsf_pkg::TURN_W-1]}}, ram_rdata};
            end
            ST_YAW_LEFT:
            begin
                alu_req.a = ltsf_pkg::ALU_W'(yaw_deadband_reg);
                alu_req.b = delta_reg;
            end
            ST_YAW_RIGHT:
            begin
                alu_req.a   = delta_reg;
                alu_req.b   = ltsf_pkg::ALU_W'(yaw_deadband_reg);
                alu_req.sub = 1'b0;
            end
            default:
            begin
                alu_req.sub = 1'b1;
            end
        endcase
    end

    // Side tracker update for a classified sample; strength comes from the adder.
    ltsf_pkg::side_t stable_next;
    ltsf_pkg::side_t pend_side_next;
    logic [1:0]      pend_cnt_next;
    logic [1:0]      pend_cnt_inc;

    assign pend_cnt_inc = (pend_side_reg == side_reg) ? (pend_cnt_reg + 2'd1) : 2'd1;

    always_comb
    begin
        stable_next    = stable_reg;
        pend_side_next = ltsf_pkg::SIDE_UNKNOWN;
        pend_cnt_next  = 2'd0;
        if ((stable_reg == ltsf_pkg::SIDE_UNKNOWN) || (side_reg == stable_reg))
        begin
            stable_next = side_reg;
        end
        else if (!alu_rsp.neg)
        begin
            // A second strong opposite sample in a row confirms the switch.
            if (pend_cnt_inc >= 2'd2)
            begin
                stable_next = side_reg;
            end
            else
            begin
                pend_side_next = side_reg;
                pend_cnt_next  = pend_cnt_inc;
            end
        end
    end

    // Final steer: the yaw decision wins, else the remembered side, unknown steers right.
    logic                         steer_left;
    logic [ltsf_pkg::STEER_W-1:0] mag_ext;
    logic [ltsf_pkg::STEER_W-1:0] steer_next;
    logic                         out_load;

    assign steer_left = used_yaw_reg ? yaw_left_reg : (stable_reg == ltsf_pkg::SIDE_LEFT);
    assign mag_ext    = {1'b0, turn_mag_reg};
    assign steer_next = steer_left ? (~mag_ext + 1'b1) : mag_ext;
    assign out_load   = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);

    assign sample.ready = (state_reg == ST_IDLE);
    assign cfg.ready    = 1'b1;

    // Configuration writes; an index beyond the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg     <= ltsf_pkg::RST_FRAME_WIDTH;
            center_deadband_reg <= ltsf_pkg::RST_CENTER_DEADBAND;
            strong_conf_reg     <= ltsf_pkg::RST_STRONG_CONFIDENCE;
            yaw_deadband_reg    <= ltsf_pkg::RST_YAW_DEADBAND;
            turn_mag_reg        <= ltsf_pkg::RST_TURN_MAGNITUDE;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                ltsf_pkg::REG_FRAME_WIDTH:
                    frame_width_reg <= cfg.data[ltsf_pkg::FW_W-1:0];
                ltsf_pkg::REG_CENTER_DEADBAND:
                    center_deadband_reg <= cfg.data[ltsf_pkg::DB_W-1:0];
                ltsf_pkg::REG_STRONG_CONFIDENCE:
                    strong_conf_reg <= cfg.data[ltsf_pkg::DB_W-1:0];
                ltsf_pkg::REG_YAW_DEADBAND:
                    yaw_deadband_reg <= cfg.data[ltsf_pkg::YD_W-1:0];
                ltsf_pkg::REG_TURN_MAGNITUDE:
                    turn_mag_reg <= cfg.data[ltsf_pkg::MAG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            stable_reg    <= ltsf_pkg::SIDE_UNKNOWN;
            pend_side_reg <= ltsf_pkg::SIDE_UNKNOWN;
            pend_cnt_reg  <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (sample.valid)
                    begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD:
                begin
                    state_reg <= (wsum_next == '0) ? ST_YAW_NEW : ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_cnt_reg == '0)
                    begin
                        state_reg <= ST_CONF_POS;
                    end
                end
                ST_CONF_POS:
                begin
                    state_reg <= alu_rsp.neg ? ST_CONF_NEG : ST_DEADBAND;
                end
                ST_CONF_NEG:
                begin
                    state_reg <= ST_DEADBAND;
                end
                ST_DEADBAND:
                begin
                    // Negative means the confidence lies beyond the center deadband.
                    state_reg <= alu_rsp.neg ? ST_TRACK : ST_YAW_NEW;
                end
                ST_TRACK:
                begin
                    wp_reg        <= (wp_reg == ltsf_pkg::PTR_LAST) ? '0 : (wp_reg + 1'b1);
                    fill_reg      <= (fill_reg < ltsf_pkg::FILL_FULL) ? (fill_reg + 1'b1)
                                                                      : fill_reg;
                    stable_reg    <= stable_next;
                    pend_side_reg <= pend_side_next;
                    pend_cnt_reg  <= pend_cnt_next;
                    state_reg     <= ST_YAW_NEW;
                end
                ST_YAW_NEW:
                begin
                    state_reg <= (fill_reg < ltsf_pkg::MIN_YAW_FILL) ? ST_DONE : ST_YAW_OLD;
                end
                ST_YAW_OLD:
                begin
                    state_reg <= ST_DELTA;
                end
                ST_DELTA:
                begin
                    state_reg <= ST_YAW_LEFT;
                end
                ST_YAW_LEFT:
                begin
                    state_reg <= alu_rsp.neg ? ST_DONE : ST_YAW_RIGHT;
                end
                ST_YAW_RIGHT:
                begin
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                mid_c_reg <= sample.mid_center;
                mid_b_reg <= sample.mid_below;
                mid_a_reg <= sample.mid_above;
                turn_reg  <= sample.lap_turn;
            end
            ST_LOAD:
            begin
                wsum_reg     <= wsum_next;
                rem_reg      <= '0;
                div_cnt_reg  <= ltsf_pkg::DIV_LAST;
                taken_reg    <= 1'b0;
                used_yaw_reg <= 1'b0;
                yaw_left_reg <= 1'b0;
                conf_reg     <= '0;
                divq_reg     <= (wsum_next == '0) ? '0 : dividend_next;
            end
            ST_DIV:
            begin
                // Restoring step: keep the difference when it did not go negative.
                if (alu_rsp.neg)
                begin
                    rem_reg <= div_shift[ltsf_pkg::REM_W-1:0];
                end
                else
                begin
                    rem_reg <= alu_rsp.res[ltsf_pkg::REM_W-1:0];
                end
                divq_reg    <= {divq_reg[ltsf_pkg::DIVD_W-2:0], !alu_rsp.neg};
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
            ST_CONF_POS:
            begin
                conf_reg <= alu_rsp.res[ltsf_pkg::MEAN_W-1:0];
                side_reg <= ltsf_pkg::SIDE_RIGHT;
            end
            ST_CONF_NEG:
            begin
                conf_reg <= alu_rsp.res[ltsf_pkg::MEAN_W-1:0];
                side_reg <= ltsf_pkg::SIDE_LEFT;
            end
            ST_TRACK:
            begin
                taken_reg <= 1'b1;
            end
            ST_YAW_OLD:
            begin
                newest_reg <= ram_rdata;
            end
            ST_DELTA:
            begin
                delta_reg <= alu_rsp.res;
            end
            ST_YAW_LEFT:
            begin
                // The yaw grew beyond the deadband: steer left.
                if (alu_rsp.neg)
                begin
                    used_yaw_reg <= 1'b1;
                    yaw_left_reg <= 1'b1;
                end
            end
            ST_YAW_RIGHT:
            begin
                // The yaw fell beyond the deadband: steer right.
                if (alu_rsp.neg)
                begin
                    used_yaw_reg <= 1'b1;
                    yaw_left_reg <= 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        if (out_load)
        begin
            res_steer_reg    <= steer_next;
            res_used_yaw_reg <= used_yaw_reg;
            res_side_reg     <= stable_reg;
            res_taken_reg    <= taken_reg;
            res_mid_reg      <= mean;
            res_conf_reg     <= conf_reg;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.steer_error     = res_steer_reg;
    assign result.used_yaw        = res_used_yaw_reg;
    assign result.remembered_side = res_side_reg;
    assign result.sample_taken    = res_taken_reg;
    assign result.sample_mid      = res_mid_reg;
    assign result.confidence      = res_conf_reg;

    // The tracker confirms a switch on the second strong sample, so it never holds two.
    `LTSF_ASSERT_IMP(a_pend_cnt_max, 1'b1, pend_cnt_reg <= 2'd1)
    // The fill count saturates at the ring depth.
    `LTSF_ASSERT_IMP(a_fill_max, 1'b1, fill_reg <= ltsf_pkg::FILL_FULL)
    // A stored sample always leaves a known remembered side.
    `LTSF_ASSERT_IMP(a_taken_side_known, result.valid && result.sample_taken,
                     result.remembered_side != ltsf_pkg::SIDE_UNKNOWN)
    // A yaw decision needs at least two stored angles.
    `LTSF_ASSERT_IMP(a_yaw_needs_history, result.valid && result.used_yaw,
                     fill_reg >= ltsf_pkg::MIN_YAW_FILL)
    // A new result beat is launched only from the final sequencer step.
    `LTSF_ASSERT_IMP(a_valid_from_done, $rose(out_valid_reg), $past(state_reg == ST_DONE))

endmodule

`default_nettype wire
